[hw/rtl/fcbf_pkg.sv]
// Shared types and constants for the flow-controlled byte FIFO.
package fcbf_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int CAP_WIDTH  = 7;
   localparam int CMD_WIDTH  = 3;
   localparam int LEN_WIDTH  = 8;

   localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_PEEK  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_POP   = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_READ  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_END   = 3'd4;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;   // take the neighbor's byte (or the head byte when wrapping)
      logic wrap;    // this cell is the tail of a rotating peek
      logic load;    // store the byte of an accepted write
   } cell_ctl_type;

endpackage

[hw/rtl/flow_controlled_byte_fifo_unit.sv]
// Top level of the flow-controlled byte FIFO: command sequencer, cell chain, result register.
// Write, end and unknown commands: accepted, then answered with one registered status result.
// Read: one byte per cycle while the result channel is free, as the chain shifts to the head cell.
// Peek: the chain rotates fully so the held bytes keep their order.
// Pop: n silent shifts, then one status result. A waiting result holds off the next command.
// Synchronous active-high reset clears counts, totals, flags and capacity (to 64); bytes are not.
module flow_controlled_byte_fifo_unit #(
   parameter int DEPTH       = 64,
   parameter int TOTAL_WIDTH = 48,
   localparam int RSP_DATA_WIDTH = ((25 + 2 * TOTAL_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration: capacity register.
   input  logic                              csr_wr_en,
   input  logic [fcbf_pkg::CAP_WIDTH-1:0]    csr_wr_data,
   // Command channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // data_byte[7:0], length[15:8]
   input  logic [fcbf_pkg::CMD_WIDTH-1:0]    req_tuser,   // command[2:0]
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte[7:0], accepted[8], occupancy[15:9], space_left[22:16],
   // written_total, read_total (TOTAL_WIDTH each), ended, at_eof, zero fill
   output logic [RSP_DATA_WIDTH-1:0]         rsp_tdata,
   output logic                              rsp_tuser,   // byte_valid
   output logic                              rsp_tlast
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int BW = fcbf_pkg::BYTE_WIDTH;
   localparam int KW = fcbf_pkg::CAP_WIDTH;
   localparam int LW = fcbf_pkg::LEN_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Control state.
   logic                   state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [TOTAL_WIDTH-1:0] wr_total_ff, wr_total_in;
   logic [TOTAL_WIDTH-1:0] rd_total_ff, rd_total_in;
   logic                   ended_ff, ended_in;
   logic [KW-1:0]          cap_ff, cap_in;
   logic [CW-1:0]          steps_ff, steps_in;
   logic [CW-1:0]          emit_ff, emit_in;
   logic                   wrap_ff, wrap_in;
   logic [IW-1:0]          tail_ff, tail_in;
   logic                   status_ff, status_in;
   logic                   acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Result payload register.
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_bvalid_ff, rsp_bvalid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_acc_ff, rsp_acc_in;

   logic [fcbf_pkg::CMD_WIDTH-1:0] cmd;
   logic [BW-1:0]   wr_byte;
   logic [LW-1:0]   req_len;
   logic [LW-1:0]   count_len;
   logic [CW-1:0]   take_n;
   logic            req_fire;
   logic            out_free;
   logic            shift_step;
   logic            emit_byte;
   logic            emit_status;
   logic            write_load;
   logic [KW-1:0]   cap_eff;
   logic [KW-1:0]   count_k;
   logic [KW-1:0]   space_left;
   logic            write_ok;

   fcbf_pkg::cell_ctl_type cell_ctl [DEPTH];
   logic [BW-1:0]          cell_byte [DEPTH];

   assign cmd       = req_tuser;
   assign wr_byte   = req_tdata[7:0];
   assign req_len   = req_tdata[15:8];
   assign count_len = LW'(count_ff);
   assign take_n    = (req_len < count_len) ? CW'(req_len) : count_ff;

   // The status fields are live, so a new command waits until the previous result has left.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign cap_eff    = (cap_ff > KW'(DEPTH)) ? KW'(DEPTH) : cap_ff;
   assign count_k    = KW'(count_ff);
   assign space_left = (cap_eff > count_k) ? (cap_eff - count_k) : '0;
   assign write_ok   = count_k < cap_eff;
   assign write_load = req_fire && (cmd == fcbf_pkg::CMD_WRITE) && write_ok;

   // Byte results shift the chain; silent steps only finish a peek rotation or a pop.
   assign emit_byte   = (state_ff == ST_RUN) && (emit_ff != '0) && out_free;
   assign shift_step  = emit_byte || ((state_ff == ST_RUN) && (emit_ff == '0) && (steps_ff != '0));
   assign emit_status = (state_ff == ST_RUN) && (emit_ff == '0) && (steps_ff == '0) &&
                        status_ff && out_free;

   // The storage chain: cell 0 holds the oldest byte.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign cell_ctl[gi].shift = shift_step;
      assign cell_ctl[gi].wrap  = wrap_ff && (tail_ff == IW'(gi));
      assign cell_ctl[gi].load  = write_load && (count_ff == CW'(gi));

      fcbf_cell u_cell (
         .clock         (clock),
         .ctl           (cell_ctl[gi]),
         .neighbor_byte (cell_byte[(gi + 1 < DEPTH) ? gi + 1 : gi]),
         .head_byte     (cell_byte[0]),
         .load_byte     (wr_byte),
         .byte_out      (cell_byte[gi])
      );
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      wr_total_in = wr_total_ff;
      rd_total_in = rd_total_ff;
      ended_in    = ended_ff;
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;
      steps_in    = steps_ff;
      emit_in     = emit_ff;
      wrap_in     = wrap_ff;
      tail_in     = tail_ff;
      status_in   = status_ff;
      acc_in      = acc_ff;

      if (req_fire) begin
         state_in  = ST_RUN;
         steps_in  = '0;
         emit_in   = '0;
         wrap_in   = 1'b0;
         status_in = 1'b1;
         acc_in    = 1'b0;
         unique case (cmd)
            fcbf_pkg::CMD_WRITE: begin
               acc_in = write_ok;
               if (write_ok) begin
                  count_in    = count_ff + CW'(1);
                  wr_total_in = wr_total_ff + TOTAL_WIDTH'(1);
               end
            end
            fcbf_pkg::CMD_PEEK: begin
               if (take_n != '0) begin
                  // Rotate the whole held run so the order is restored.
                  emit_in   = take_n;
                  steps_in  = count_ff;
                  wrap_in   = 1'b1;
                  tail_in   = IW'(count_ff - CW'(1));
                  status_in = 1'b0;
               end
            end
            fcbf_pkg::CMD_POP: begin
               steps_in    = take_n;
               count_in    = count_ff - take_n;
               rd_total_in = rd_total_ff + TOTAL_WIDTH'(take_n);
            end
            fcbf_pkg::CMD_READ: begin
               emit_in     = take_n;
               steps_in    = take_n;
               status_in   = (take_n == '0);
               count_in    = count_ff - take_n;
               rd_total_in = rd_total_ff + TOTAL_WIDTH'(take_n);
            end
            fcbf_pkg::CMD_END: begin
               ended_in = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (state_ff == ST_RUN) begin
         if (shift_step) begin
            steps_in = steps_ff - CW'(1);
         end
         if (emit_byte) begin
            emit_in = emit_ff - CW'(1);
         end
         if (emit_status) begin
            status_in = 1'b0;
         end
         if ((emit_byte && (emit_ff == CW'(1)) && (steps_ff == CW'(1)) && !status_ff) ||
             emit_status ||
             ((emit_ff == '0) && (steps_ff == CW'(1)) && !status_ff) ||
             ((emit_ff == '0) && (steps_ff == '0) && !status_ff)) begin
            state_in = ST_IDLE;
            wrap_in  = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_acc_in    = rsp_acc_ff;
      if (emit_byte) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = cell_byte[0];
         rsp_bvalid_in = 1'b1;
         rsp_last_in   = (emit_ff == CW'(1));
         rsp_acc_in    = 1'b0;
      end else if (emit_status) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = '0;
         rsp_bvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_acc_in    = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wr_total_ff  <= '0;
         rd_total_ff  <= '0;
         ended_ff     <= 1'b0;
         cap_ff       <= KW'(64);
         steps_ff     <= '0;
         emit_ff      <= '0;
         wrap_ff      <= 1'b0;
         tail_ff      <= '0;
         status_ff    <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_total_ff  <= wr_total_in;
         rd_total_ff  <= rd_total_in;
         ended_ff     <= ended_in;
         cap_ff       <= cap_in;
         steps_ff     <= steps_in;
         emit_ff      <= emit_in;
         wrap_ff      <= wrap_in;
         tail_ff      <= tail_in;
         status_ff    <= status_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_acc_ff    <= rsp_acc_in;
   end

   // Status fields come from the live registers, which already hold the post-command state.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_bvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({ (ended_ff && (count_ff == '0)),
                                         ended_ff,
                                         rd_total_ff,
                                         wr_total_ff,
                                         space_left,
                                         count_k,
                                         rsp_acc_ff,
                                         rsp_byte_ff });

`ifndef SYNTHESIS
   a_emit_within_steps: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= steps_ff)
      else $error("byte results outnumber chain shifts");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((emit_ff == '0) && (steps_ff == '0) && !status_ff))
      else $error("sequencer idle with work pending");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      write_load |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("stored write did not raise occupancy");

   a_peek_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !req_fire |=> (count_ff == $past(count_ff)))
      else $error("occupancy changed while a command was in progress");
`endif

endmodule

[hw/rtl/fcbf_cell.sv]
// One byte cell of the shifting storage chain.
module fcbf_cell (
   input  logic                                clock,
   input  fcbf_pkg::cell_ctl_type              ctl,
   input  logic [fcbf_pkg::BYTE_WIDTH-1:0]     neighbor_byte,
   input  logic [fcbf_pkg::BYTE_WIDTH-1:0]     head_byte,
   input  logic [fcbf_pkg::BYTE_WIDTH-1:0]     load_byte,
   output logic [fcbf_pkg::BYTE_WIDTH-1:0]     byte_out
);

   logic [fcbf_pkg::BYTE_WIDTH-1:0] byte_ff;
   logic [fcbf_pkg::BYTE_WIDTH-1:0] byte_in;

   always_comb begin
      priority if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift && ctl.wrap) begin
         byte_in = head_byte;
      end else if (ctl.shift) begin
         byte_in = neighbor_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

[sim/flow_controlled_byte_fifo_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the byte FIFO: shadows the FIFO state, predicts each result beat and compares it.
module flow_controlled_byte_fifo_unit_checker #(
   parameter int DEPTH       = 64,
   parameter int TOTAL_WIDTH = 48,
   parameter int RSP_WIDTH   = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [fcbf_pkg::CAP_WIDTH-1:0] csr_wr_data,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // data_byte[7:0], length[15:8]
   input  logic [fcbf_pkg::CMD_WIDTH-1:0] req_tuser,   // command[2:0]
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte[7:0], accepted[8], occupancy[15:9], space_left[22:16],
   // written_total, read_total, ended, at_eof, zero fill
   input  logic [RSP_WIDTH-1:0]           rsp_tdata,
   input  logic                           rsp_tuser,   // byte_valid
   input  logic                           rsp_tlast,
   output int                             fail_count,
   output int                             pending_count,
   output int                             beat_count
);

   typedef struct packed {
      logic [fcbf_pkg::BYTE_WIDTH-1:0] out_byte;
      logic                            byte_valid;
      logic                            last;
      logic                            accepted;
      logic [fcbf_pkg::CAP_WIDTH-1:0]  occupancy;
      logic [fcbf_pkg::CAP_WIDTH-1:0]  space_left;
      logic [TOTAL_WIDTH-1:0]          written_total;
      logic [TOTAL_WIDTH-1:0]          read_total;
      logic                            ended;
      logic                            at_eof;
   } fifo_beat_type;

   logic [fcbf_pkg::BYTE_WIDTH-1:0] shadow_bytes [DEPTH];
   int                              shadow_head;
   int                              shadow_held;
   logic [TOTAL_WIDTH-1:0]          shadow_in_total;
   logic [TOTAL_WIDTH-1:0]          shadow_out_total;
   logic                            shadow_ended;
   logic [fcbf_pkg::CAP_WIDTH-1:0]  shadow_capacity;
   fifo_beat_type                   outbound_beats [$];

   // A capacity above the store depth behaves as the full depth.
   function automatic int usable_capacity();
      return (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
   endfunction

   function automatic fifo_beat_type status_beat(logic [fcbf_pkg::BYTE_WIDTH-1:0] value,
                                                 logic valid, logic last_flag, logic stored);
      fifo_beat_type beat;
      int            room;
      room               = usable_capacity();
      beat.out_byte      = value;
      beat.byte_valid    = valid;
      beat.last          = last_flag;
      beat.accepted      = stored;
      beat.occupancy     = fcbf_pkg::CAP_WIDTH'(shadow_held);
      beat.space_left    = (room > shadow_held) ? fcbf_pkg::CAP_WIDTH'(room - shadow_held) : '0;
      beat.written_total = shadow_in_total;
      beat.read_total    = shadow_out_total;
      beat.ended         = shadow_ended;
      beat.at_eof        = shadow_ended && (shadow_held == 0);
      return beat;
   endfunction

   task automatic queue_beat(fifo_beat_type beat);
      outbound_beats.insert(outbound_beats.size(), beat);
   endtask

   task automatic execute_fifo_command(logic [fcbf_pkg::CMD_WIDTH-1:0] cmd,
                                       logic [fcbf_pkg::BYTE_WIDTH-1:0] data,
                                       logic [fcbf_pkg::LEN_WIDTH-1:0] len);
      logic [fcbf_pkg::BYTE_WIDTH-1:0] taken [DEPTH];
      int                              n;
      logic                            stored;
      case (cmd)
         fcbf_pkg::CMD_WRITE: begin
            stored = shadow_held < usable_capacity();
            if (stored) begin
               shadow_bytes[(shadow_head + shadow_held) % DEPTH] = data;
               shadow_held++;
               shadow_in_total++;
            end
            queue_beat(status_beat('0, 1'b0, 1'b1, stored));
         end
         fcbf_pkg::CMD_END: begin
            shadow_ended = 1'b1;
            queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0));
         end
         fcbf_pkg::CMD_PEEK, fcbf_pkg::CMD_POP, fcbf_pkg::CMD_READ: begin
            n = (int'(len) < shadow_held) ? int'(len) : shadow_held;
            for (int i = 0; i < n; i++) begin
               taken[i] = shadow_bytes[(shadow_head + i) % DEPTH];
            end
            if (cmd != fcbf_pkg::CMD_PEEK) begin
               shadow_head      = (shadow_head + n) % DEPTH;
               shadow_held      = shadow_held - n;
               shadow_out_total = shadow_out_total + TOTAL_WIDTH'(n);
            end
            // Status after the whole command goes into every beat, so the pop comes first.
            if (cmd == fcbf_pkg::CMD_POP || n == 0) begin
               queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0));
            end else begin
               for (int i = 0; i < n; i++) begin
                  queue_beat(status_beat(taken[i], 1'b1, i == n - 1, 1'b0));
               end
            end
         end
         default: begin
            queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0));
         end
      endcase
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      fifo_beat_type got;
      fifo_beat_type want;
      if (reset) begin
         shadow_head      = 0;
         shadow_held      = 0;
         shadow_in_total  = '0;
         shadow_out_total = '0;
         shadow_ended     = 1'b0;
         shadow_capacity  = fcbf_pkg::CAP_WIDTH'(64);
         outbound_beats.delete();
      end else begin
         if (csr_wr_en) begin
            shadow_capacity = csr_wr_data;
         end
         // Results are checked before new commands: no command answers in its own cycle.
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte      = rsp_tdata[7:0];
            got.byte_valid    = rsp_tuser;
            got.last          = rsp_tlast;
            got.accepted      = rsp_tdata[8];
            got.occupancy     = rsp_tdata[15:9];
            got.space_left    = rsp_tdata[22:16];
            got.written_total = rsp_tdata[23 +: TOTAL_WIDTH];
            got.read_total    = rsp_tdata[23 + TOTAL_WIDTH +: TOTAL_WIDTH];
            got.ended         = rsp_tdata[23 + 2 * TOTAL_WIDTH];
            got.at_eof        = rsp_tdata[24 + 2 * TOTAL_WIDTH];
            beat_count++;
            if (outbound_beats.size() == 0) begin
               fail_count++;
               $display("%0t ns: result beat mismatch, expected no beat, actual data 0x%0h", $time,
                        rsp_tdata);
            end else begin
               want = outbound_beats.pop_front();
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("byte_valid", want.byte_valid, got.byte_valid);
               compare_field("last", want.last, got.last);
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("occupancy", want.occupancy, got.occupancy);
               compare_field("space_left", want.space_left, got.space_left);
               compare_field("written_total", want.written_total, got.written_total);
               compare_field("read_total", want.read_total, got.read_total);
               compare_field("ended", want.ended, got.ended);
               compare_field("at_eof", want.at_eof, got.at_eof);
            end
         end
         if (req_tvalid && req_tready) begin
            execute_fifo_command(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         end
      end
      pending_count <= outbound_beats.size();
   end

endmodule

[sim/flow_controlled_byte_fifo_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the byte FIFO: clock, reset, command stimulus, result back-pressure, verdict.
module flow_controlled_byte_fifo_unit_tb;

   localparam int DEPTH         = 64;
   localparam int TOTAL_WIDTH   = 48;
   localparam int RSP_WIDTH     = ((25 + 2 * TOTAL_WIDTH + 7) / 8) * 8;
   localparam int MAX_IDLE      = 7;
   localparam int SETTLE_CYCLES = 100;
   localparam int TIMEOUT_NS    = 4_000_000;
   localparam int PHASES        = 5;

   localparam logic [fcbf_pkg::CMD_WIDTH-1:0] CMD_UNKNOWN_LOW  = fcbf_pkg::CMD_END + 1'b1;
   localparam logic [fcbf_pkg::CMD_WIDTH-1:0] CMD_UNKNOWN_HIGH = '1;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [fcbf_pkg::CAP_WIDTH-1:0]  csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [15:0]                     req_tdata   = '0;
   logic [fcbf_pkg::CMD_WIDTH-1:0]  req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [RSP_WIDTH-1:0]            rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   logic                  rsp_idle_on    = 1'b0;
   int                    rsp_stall_left = 0;
   bit                    req_idle_on    = 1'b1;
   int                    commands_sent  = 0;
   int                    settings_used  = 0;
   int                    fail_count;
   int                    pending_count;
   int                    beat_count;

   always #2 clock = ~clock;

   flow_controlled_byte_fifo_unit #(
      .DEPTH       (DEPTH),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   flow_controlled_byte_fifo_unit_checker #(
      .DEPTH       (DEPTH),
      .TOTAL_WIDTH (TOTAL_WIDTH),
      .RSP_WIDTH   (RSP_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .beat_count    (beat_count)
   );

   // After each result transfer the receiver may hold tready low for a random stall.
   always @(posedge clock) begin
      int draw;
      draw = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_stall_left <= draw;
         rsp_tready     <= (draw == 0);
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= (rsp_stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_command(logic [fcbf_pkg::CMD_WIDTH-1:0] cmd,
                               logic [fcbf_pkg::BYTE_WIDTH-1:0] data,
                               logic [fcbf_pkg::LEN_WIDTH-1:0] len);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {len, data};
      do @(posedge clock); while (!req_tready);
      commands_sent++;
   endtask

   // Mostly writes while filling, mostly pops and reads while draining.
   task automatic send_random_command(bit filling);
      int                             pick;
      logic [fcbf_pkg::CMD_WIDTH-1:0] cmd;
      logic [fcbf_pkg::LEN_WIDTH-1:0] len;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 93 : 20)) cmd = fcbf_pkg::CMD_WRITE;
      else if (pick < (filling ? 97 : 32)) cmd = fcbf_pkg::CMD_PEEK;
      else if (pick < (filling ? 97 : 50)) cmd = fcbf_pkg::CMD_POP;
      else if (pick < (filling ? 97 : 90)) cmd = fcbf_pkg::CMD_READ;
      else if (pick < (filling ? 98 : 93)) cmd = fcbf_pkg::CMD_END;
      else cmd = fcbf_pkg::CMD_WIDTH'($urandom_range(CMD_UNKNOWN_LOW, CMD_UNKNOWN_HIGH));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: len = fcbf_pkg::LEN_WIDTH'($urandom_range(0, 8));
         6, 7:             len = fcbf_pkg::LEN_WIDTH'($urandom_range(0, 70));
         8:                len = '1;
         default:          len = fcbf_pkg::LEN_WIDTH'($urandom);
      endcase
      send_command(cmd, fcbf_pkg::BYTE_WIDTH'($urandom), len);
   endtask

   // Waits for every predicted beat, then lets a trailing peek rotation finish.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [fcbf_pkg::CAP_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int phase_caps [PHASES];
      int phase_items [PHASES];
      int usable;
      int regime_len;
      phase_caps[0]  = DEPTH;
      phase_caps[1]  = 5;
      phase_caps[2]  = $urandom_range(1, DEPTH);
      phase_caps[3]  = 1;
      phase_caps[4]  = 100;
      phase_items[0] = 130;
      for (int p = 1; p < PHASES; p++) begin
         phase_items[p] = 70;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty FIFO, unknown commands, then a short fill and drain.
      write_capacity(7'd64);
      send_command(fcbf_pkg::CMD_PEEK, 8'h00, 8'd5);
      send_command(fcbf_pkg::CMD_READ, 8'hFF, 8'd0);
      send_command(fcbf_pkg::CMD_POP, 8'h00, 8'hFF);
      send_command(CMD_UNKNOWN_HIGH, 8'hFF, 8'hFF);
      send_command(CMD_UNKNOWN_LOW, 8'h00, 8'h00);
      send_command(fcbf_pkg::CMD_WRITE, 8'h00, 8'hFF);
      send_command(fcbf_pkg::CMD_WRITE, 8'hFF, 8'h00);
      send_command(fcbf_pkg::CMD_WRITE, 8'hA5, 8'h5A);
      send_command(fcbf_pkg::CMD_WRITE, 8'h5A, 8'hA5);
      send_command(fcbf_pkg::CMD_PEEK, 8'h00, 8'd0);
      send_command(fcbf_pkg::CMD_PEEK, 8'h00, 8'hFF);
      send_command(fcbf_pkg::CMD_READ, 8'h00, 8'd1);
      send_command(fcbf_pkg::CMD_POP, 8'h00, 8'd1);
      send_command(fcbf_pkg::CMD_READ, 8'h00, 8'hFF);
      drain_results();
      write_capacity(7'd1);
      send_command(fcbf_pkg::CMD_WRITE, 8'h11, 8'h00);
      send_command(fcbf_pkg::CMD_WRITE, 8'h22, 8'h00);
      drain_results();
      // Capacity now sits below the occupancy.
      write_capacity(7'd0);
      send_command(fcbf_pkg::CMD_WRITE, 8'h33, 8'h00);
      drain_results();
      write_capacity(7'h7F);
      send_command(fcbf_pkg::CMD_WRITE, 8'h44, 8'h00);
      send_command(fcbf_pkg::CMD_POP, 8'h00, 8'd1);
      send_command(fcbf_pkg::CMD_READ, 8'h00, 8'hFF);
      send_command(fcbf_pkg::CMD_END, 8'h00, 8'h00);
      send_command(fcbf_pkg::CMD_WRITE, 8'h55, 8'h00);
      send_command(fcbf_pkg::CMD_PEEK, 8'h00, 8'hFF);

      // Random phases alternate fill and drain runs sized to the capacity so full is reached.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_capacity(fcbf_pkg::CAP_WIDTH'(phase_caps[p]));
         usable      = (phase_caps[p] > DEPTH) ? DEPTH : phase_caps[p];
         regime_len  = usable + usable / 4 + 4;
         req_idle_on = (p != 1 && p != 3);
         rsp_idle_on <= (p != 1 && p != 2);
         for (int i = 0; i < phase_items[p]; i++) begin
            send_random_command((i / regime_len) % 2 == 0);
         end
      end
      drain_results();

      $display("Sent %0d commands over %0d capacity settings, checked %0d result beats.",
               commands_sent, settings_used, beat_count);
      $display("Covered empty and full FIFO, clamped peeks and reads,");
      $display("unknown commands and end of input.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule

[flow_controlled_byte_fifo_unit.f]
hw/rtl/fcbf_pkg.sv
hw/rtl/fcbf_cell.sv
hw/rtl/flow_controlled_byte_fifo_unit.sv
sim/flow_controlled_byte_fifo_unit_checker.sv
sim/flow_controlled_byte_fifo_unit_tb.sv
